// ===== rtl/spfc_pkg.sv =====
// Shared types, constants and the CRC byte update for the servo packet framer.
`default_nettype none

package spfc_pkg;

   localparam int PARAM_COUNT_W    = 10;
   localparam int MAX_PARAMS_DEF   = 1023;
   localparam int QUEUE_DEPTH_DEF  = 4;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_PARAM = 1'b1;

   localparam logic [15:0] CRC_POLY = 16'h8005;

   // Byte positions within one packet as seen by the output sequencer.
   typedef enum logic [9:0] {
      PH_SYNC0  = 10'b00_0000_0001,
      PH_SYNC1  = 10'b00_0000_0010,
      PH_SYNC2  = 10'b00_0000_0100,
      PH_RSVD   = 10'b00_0000_1000,
      PH_ID     = 10'b00_0001_0000,
      PH_LEN_LO = 10'b00_0010_0000,
      PH_LEN_HI = 10'b00_0100_0000,
      PH_BODY   = 10'b00_1000_0000,
      PH_CRC_LO = 10'b01_0000_0000,
      PH_CRC_HI = 10'b10_0000_0000
   } phase_type;

   localparam logic [7:0] HDR_SYNC  = 8'hFF;
   localparam logic [7:0] HDR_SYNC2 = 8'hFD;
   localparam logic [7:0] HDR_RSVD  = 8'h00;
   localparam logic [15:0] LEN_EXTRA = 16'd3;

   typedef struct packed {
      logic                     kind;
      logic [7:0]               device_id;
      logic [7:0]               instruction;
      logic [PARAM_COUNT_W-1:0] param_count;
      logic [7:0]               param_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // One classified command handed from the front to the back.
   typedef struct packed {
      logic                     is_start;
      logic                     close;
      logic [7:0]               device_id;
      logic [7:0]               instruction;
      logic [PARAM_COUNT_W-1:0] count;
      logic [7:0]               data;
   } cmd_type;

   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/spfc_front.sv =====
// Front end: accepts request words, tracks the open packet and queues commands.
`default_nettype none

module spfc_front
   import spfc_pkg::*;
#(
   parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    queue_full,
   output logic         push,
   output cmd_type      push_cmd
);

   localparam logic [16:0] MAX_LIMIT = 17'(MAX_PARAMS);

   logic [PARAM_COUNT_W-1:0] remaining_ff, remaining_in;
   logic [PARAM_COUNT_W-1:0] sat_count;
   logic                     accept;
   logic                     is_start;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_start  = (req_data.kind == KIND_START);

   always_comb begin
      if (17'(req_data.param_count) > MAX_LIMIT) begin
         sat_count = MAX_LIMIT[PARAM_COUNT_W-1:0];
      end else begin
         sat_count = req_data.param_count;
      end
   end

   // A parameter word with no packet open is accepted and simply dropped.
   assign push = accept && (is_start || (remaining_ff != '0));

   always_comb begin
      push_cmd.is_start    = is_start;
      push_cmd.device_id   = req_data.device_id;
      push_cmd.instruction = req_data.instruction;
      push_cmd.count       = sat_count;
      push_cmd.data        = req_data.param_byte;
      if (is_start) begin
         push_cmd.close = (sat_count == '0);
      end else begin
         push_cmd.close = (remaining_ff == PARAM_COUNT_W'(1));
      end
   end

   always_comb begin
      remaining_in = remaining_ff;
      if (push) begin
         if (is_start) begin
            remaining_in = sat_count;
         end else begin
            remaining_in = remaining_ff - PARAM_COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
      end else begin
         remaining_ff <= remaining_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/spfc_queue.sv =====
// Short command queue decoupling the front end from the byte sequencer.
`default_nettype none

module spfc_queue
   import spfc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         empty,
   output logic         full,
   output cmd_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   cmd_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("command pushed into a full queue");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// ===== rtl/spfc_back.sv =====
// Back end: expands queued commands into packet bytes and keeps the running CRC.
`default_nettype none

module spfc_back
   import spfc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    empty,
   input  wire cmd_type head,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic                mid_ff, mid_in;
   phase_type           phase_ff, phase_in;
   logic [15:0]         crc_ff, crc_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff;
   rsp_type             out_in;
   logic                load;
   logic                emit;
   logic                done;
   phase_type           eff_phase;
   phase_type           next_phase;
   logic [15:0]         crc_base;
   logic [15:0]         len;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // The output register takes a new word whenever it is empty or being drained.
   assign load = !out_valid_ff || !rsp_stall;
   assign emit = load && !empty;

   // A parameter command enters the sequence at the body position.
   assign eff_phase = mid_ff ? phase_ff : (head.is_start ? PH_SYNC0 : PH_BODY);
   assign crc_base  = (eff_phase == PH_SYNC0) ? 16'h0000 : crc_ff;
   assign len       = 16'(head.count) + LEN_EXTRA;

   always_comb begin
      out_in.last = (eff_phase == PH_CRC_HI);
      unique case (eff_phase)
         PH_SYNC0  : out_in.out_byte = HDR_SYNC;
         PH_SYNC1  : out_in.out_byte = HDR_SYNC;
         PH_SYNC2  : out_in.out_byte = HDR_SYNC2;
         PH_RSVD   : out_in.out_byte = HDR_RSVD;
         PH_ID     : out_in.out_byte = head.device_id;
         PH_LEN_LO : out_in.out_byte = len[7:0];
         PH_LEN_HI : out_in.out_byte = len[15:8];
         PH_BODY   : out_in.out_byte = head.is_start ? head.instruction : head.data;
         PH_CRC_LO : out_in.out_byte = crc_ff[7:0];
         PH_CRC_HI : out_in.out_byte = crc_ff[15:8];
         default   : out_in.out_byte = HDR_RSVD;
      endcase
   end

   always_comb begin
      unique case (eff_phase)
         PH_SYNC0  : next_phase = PH_SYNC1;
         PH_SYNC1  : next_phase = PH_SYNC2;
         PH_SYNC2  : next_phase = PH_RSVD;
         PH_RSVD   : next_phase = PH_ID;
         PH_ID     : next_phase = PH_LEN_LO;
         PH_LEN_LO : next_phase = PH_LEN_HI;
         PH_LEN_HI : next_phase = PH_BODY;
         PH_BODY   : next_phase = PH_CRC_LO;
         PH_CRC_LO : next_phase = PH_CRC_HI;
         PH_CRC_HI : next_phase = PH_SYNC0;
         default   : next_phase = PH_SYNC0;
      endcase
   end

   assign done = ((eff_phase == PH_BODY) && !head.close) || (eff_phase == PH_CRC_HI);
   assign pop  = emit && done;

   always_comb begin
      mid_in       = mid_ff;
      phase_in     = phase_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = !empty;
      end
      if (emit) begin
         mid_in   = !done;
         phase_in = next_phase;
         if ((eff_phase != PH_CRC_LO) && (eff_phase != PH_CRC_HI)) begin
            crc_in = crc16_feed(crc_base, out_in.out_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff       <= 1'b0;
         phase_ff     <= PH_SYNC0;
         crc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_ff       <= mid_in;
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= out_in;
      end
   end

   a_mid_has_command : assert property (@(posedge clock) disable iff (reset)
      mid_ff |-> !empty)
      else $error("sequencer is part way through a command that left the queue");

   a_phase_in_range : assert property (@(posedge clock) disable iff (reset)
      mid_ff |-> ($onehot(phase_ff) && phase_ff != PH_SYNC0))
      else $error("sequencer phase out of range");

endmodule

`default_nettype wire

// ===== rtl/servo_packet_framer_crc16.sv =====
// Top level of the servo packet framer with CRC-16 trailer.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_type: kind, id, instruction, count, byte
//   rsp     | out       | rsp_valid / rsp_stall | rsp_type: out_byte, last
//
// Each parameter word yields one byte; the word that closes a packet
// adds two CRC bytes, and a start word yields eight bytes (ten with no parameters).
// The output sequencer emits one byte per cycle unless rsp stalls; the command queue
// absorbs the difference, and req_stall rises only while the queue is full.
// Reset is synchronous and clears the queue, the packet tracking and the CRC.
// A stall on rsp holds the output word; the front keeps accepting until the queue fills.
`default_nettype none

module servo_packet_framer_crc16
   import spfc_pkg::*;
#(
   parameter int MAX_PARAMS  = MAX_PARAMS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    empty;
   logic    full;
   cmd_type head;

   spfc_front #(
      .MAX_PARAMS (MAX_PARAMS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   spfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .empty    (empty),
      .full     (full),
      .head     (head)
   );

   spfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the servo packet framer: drives start and parameter words and checks each byte.
`timescale 1ns / 1ps

module tb;
   import spfc_pkg::*;

   localparam int RAND_WORDS   = 260;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 32;

   typedef enum {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   typedef struct {
      req_type     word;
      int          n_exp;
      int          n_head;
      logic [63:0] head;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Framer state as the testbench sees it.
   logic [15:0] crc_acc     = '0;
   logic [9:0]  params_left = '0;
   logic        pkt_open    = 1'b0;

   rsp_type      fresh_bytes[$];
   rsp_type      due_bytes[$];
   stim_row_type script[$];

   // Typed expectations travel with the word on the bus.
   int          cur_n_exp  = -1;
   int          cur_n_head = 0;
   logic [63:0] cur_head   = '0;

   int          errors      = 0;
   int          idle_cycles = 0;
   int          words_sent  = 0;
   int          burst_left  = 0;
   rx_mode_type rx_mode     = RX_FLOW;
   int          rx_span     = 0;

   servo_packet_framer_crc16 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c;
      for (int i = 7; i >= 0; i--) begin
         if (r[15] ^ b[i]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic void put_byte(input logic [7:0] b, input logic lst, input bit feed);
      rsp_type r;
      r.out_byte = b;
      r.last     = lst;
      fresh_bytes.push_back(r);
      if (feed) begin
         crc_acc = crc_byte(crc_acc, b);
      end
   endfunction

   function automatic void close_frame();
      logic [15:0] c;
      c = crc_acc;
      put_byte(c[7:0], 1'b0, 1'b0);
      put_byte(c[15:8], 1'b1, 1'b0);
      pkt_open    = 1'b0;
      params_left = '0;
      crc_acc     = '0;
   endfunction

   // Appends to fresh_bytes every byte that one accepted word should produce.
   function automatic void frame_word(input req_type w);
      logic [9:0]  cnt;
      logic [15:0] len;
      if (w.kind == KIND_START) begin
         cnt = w.param_count;
         if (cnt > MAX_PARAMS_DEF) begin
            cnt = PARAM_COUNT_W'(MAX_PARAMS_DEF);
         end
         len     = {6'd0, cnt} + LEN_EXTRA;
         crc_acc = '0;
         put_byte(HDR_SYNC, 1'b0, 1'b1);
         put_byte(HDR_SYNC, 1'b0, 1'b1);
         put_byte(HDR_SYNC2, 1'b0, 1'b1);
         put_byte(HDR_RSVD, 1'b0, 1'b1);
         put_byte(w.device_id, 1'b0, 1'b1);
         put_byte(len[7:0], 1'b0, 1'b1);
         put_byte(len[15:8], 1'b0, 1'b1);
         put_byte(w.instruction, 1'b0, 1'b1);
         pkt_open    = 1'b1;
         params_left = cnt;
         if (cnt == 0) begin
            close_frame();
         end
      end else if (pkt_open && params_left != 0) begin
         put_byte(w.param_byte, 1'b0, 1'b1);
         params_left--;
         if (params_left == 0) begin
            close_frame();
         end
      end
   endfunction

   function automatic stim_row_type mk_row(input logic kind, input logic [7:0] id, instr,
                                           input logic [9:0] cnt, input logic [7:0] pb,
                                           input int n_exp, n_head, input logic [63:0] head);
      stim_row_type s;
      s.word.kind        = kind;
      s.word.device_id   = id;
      s.word.instruction = instr;
      s.word.param_count = cnt;
      s.word.param_byte  = pb;
      s.n_exp            = n_exp;
      s.n_head           = n_head;
      s.head             = head;
      return s;
   endfunction

   function automatic req_type noise_word();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   // Called just after a falling edge; returns just after the falling edge that follows acceptance.
   task automatic send_word(input req_type w, input int n_exp, input int n_head,
                            input logic [63:0] head);
      int gap;
      if (burst_left == 0) begin
         gap       = $urandom_range(1, 12);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 16);
      end
      burst_left--;
      req_data   = w;
      cur_n_exp  = n_exp;
      cur_n_head = n_head;
      cur_head   = head;
      req_valid  = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_param();
      req_type w;
      w      = noise_word();
      w.kind = KIND_PARAM;
      send_word(w, -1, 0, '0);
   endtask

   // The receiver stalls on a pattern of its own, picking a new stall mode at random whenever its span runs out.
   always @(negedge clock) begin
      if (rx_span == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_span = $urandom_range(10, 80);
      end else begin
         rx_span--;
      end
      case (rx_mode)
         RX_FLOW: begin
            rsp_stall = 1'b0;
         end
         RX_LIGHT: begin
            rsp_stall = ($urandom_range(0, 3) == 0);
         end
         RX_HEAVY: begin
            rsp_stall = ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall = (rx_span % 7) < 3;
         end
      endcase
   end

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      logic    progress;
      progress = 1'b0;
      if (!reset && req_valid && req_stall === 1'b0) begin
         progress = 1'b1;
         fresh_bytes.delete();
         frame_word(req_data);
         if (cur_n_exp >= 0 && fresh_bytes.size() != cur_n_exp) begin
            $display("%0t: byte count for word %h: expected %0d, actual %0d",
                     $time, req_data, cur_n_exp, fresh_bytes.size());
            errors++;
         end
         foreach (fresh_bytes[i]) begin
            want = fresh_bytes[i];
            if (i < cur_n_head) begin
               want.out_byte = cur_head[63 - 8*i -: 8];
            end
            due_bytes.push_back(want);
         end
      end
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         progress = 1'b1;
         if (due_bytes.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual byte %h last %b",
                     $time, rsp_data.out_byte, rsp_data.last);
            errors++;
         end else begin
            want = due_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $display("%0t: out_byte mismatch: expected %h, actual %h",
                        $time, want.out_byte, rsp_data.out_byte);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t: last mismatch: expected %b, actual %b",
                        $time, want.last, rsp_data.last);
               errors++;
            end
         end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      req_type w;
      int      pick;
      int      cnt;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;

      // Directed part: dropped words, empty packets, extremes, abandoned packets.
      script.push_back(mk_row(KIND_PARAM, 8'h00, 8'h00, 10'h000, 8'hFF, 0, 0, '0));
      script.push_back(mk_row(KIND_START, 8'h00, 8'h00, 10'h000, 8'hFF, 10, 8,
                              64'hFFFF_FD00_0003_0000));
      script.push_back(mk_row(KIND_START, 8'hFF, 8'hFF, 10'h000, 8'h00, 10, 8,
                              64'hFFFF_FD00_FF03_00FF));
      script.push_back(mk_row(KIND_START, 8'hFE, 8'h03, 10'h001, 8'h00, 8, 8,
                              64'hFFFF_FD00_FE04_0003));
      script.push_back(mk_row(KIND_PARAM, 8'hFF, 8'hFF, 10'h3FF, 8'h00, 3, 1, {8'h00, 56'h0}));
      script.push_back(mk_row(KIND_PARAM, 8'h00, 8'h00, 10'h000, 8'h55, 0, 0, '0));
      script.push_back(mk_row(KIND_START, 8'h01, 8'h83, 10'h002, 8'hAA, 8, 8,
                              64'hFFFF_FD00_0105_0083));
      script.push_back(mk_row(KIND_PARAM, 8'hFF, 8'hFF, 10'h3FF, 8'hFF, 1, 1, {8'hFF, 56'h0}));
      script.push_back(mk_row(KIND_PARAM, 8'h00, 8'h00, 10'h000, 8'h00, 3, 1, {8'h00, 56'h0}));
      script.push_back(mk_row(KIND_START, 8'h7A, 8'h02, 10'h3FF, 8'h00, 8, 8,
                              64'hFFFF_FD00_7A02_0402));
      script.push_back(mk_row(KIND_PARAM, 8'h00, 8'h00, 10'h000, 8'hA5, 1, 1, {8'hA5, 56'h0}));
      script.push_back(mk_row(KIND_PARAM, 8'h00, 8'h00, 10'h000, 8'h5A, 1, 1, {8'h5A, 56'h0}));
      script.push_back(mk_row(KIND_START, 8'h02, 8'h01, 10'h003, 8'h00, 8, 8,
                              64'hFFFF_FD00_0206_0001));
      script.push_back(mk_row(KIND_PARAM, 8'h00, 8'h00, 10'h000, 8'h12, 1, 1, {8'h12, 56'h0}));
      script.push_back(mk_row(KIND_START, 8'h03, 8'h04, 10'h000, 8'h00, 10, 8,
                              64'hFFFF_FD00_0303_0004));
      script.push_back(mk_row(KIND_PARAM, 8'h00, 8'h00, 10'h000, 8'h34, 0, 0, '0));
      script.push_back(mk_row(KIND_START, 8'h10, 8'h03, 10'h004, 8'h00, 8, 8,
                              64'hFFFF_FD00_1007_0003));
      script.push_back(mk_row(KIND_PARAM, 8'h00, 8'h00, 10'h000, 8'h01, 1, 1, {8'h01, 56'h0}));
      script.push_back(mk_row(KIND_PARAM, 8'h00, 8'h00, 10'h000, 8'h80, 1, 1, {8'h80, 56'h0}));
      script.push_back(mk_row(KIND_PARAM, 8'h00, 8'h00, 10'h000, 8'h7F, 1, 1, {8'h7F, 56'h0}));
      script.push_back(mk_row(KIND_PARAM, 8'h00, 8'h00, 10'h000, 8'hFE, 3, 1, {8'hFE, 56'h0}));

      repeat (2) @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         send_word(script[i].word, script[i].n_exp, script[i].n_head, script[i].head);
      end

      // Mostly complete packets with random content; the rest are cut-short packets
      // and stray words.
      while (words_sent < script.size() + RAND_WORDS) begin
         pick = $urandom_range(0, 9);
         w    = noise_word();
         if (pick < 7) begin
            cnt           = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 30)
                                                        : $urandom_range(0, 6);
            w.kind        = KIND_START;
            w.param_count = PARAM_COUNT_W'(cnt);
            send_word(w, -1, 0, '0);
            repeat (cnt) send_param();
         end else if (pick < 9) begin
            w.kind = KIND_START;
            send_word(w, -1, 0, '0);
            repeat ($urandom_range(0, 4)) send_param();
         end else begin
            send_word(w, -1, 0, '0);
         end
      end
      req_valid = 1'b0;

      while (due_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== servo_packet_framer_crc16.f =====
rtl/spfc_pkg.sv
rtl/spfc_front.sv
rtl/spfc_queue.sv
rtl/spfc_back.sv
rtl/servo_packet_framer_crc16.sv
sim/tb.sv
